### design/hmm_pkg.sv
// Shared types, constants and decode helpers of the memory map bus slave.
`default_nettype none
package hmm_pkg;

	localparam int WramDepth = 4096;
	localparam int WramAw    = 12;
	localparam int HramDepth = 127;
	localparam int HramAw    = 7;
	localparam int IoCount   = 17;
	localparam int IoSelW    = 5;

	typedef enum logic [3:0] {
		REG_ROM0     = 4'd0,
		REG_ROMX     = 4'd1,
		REG_VRAM     = 4'd2,
		REG_EXTRAM   = 4'd3,
		REG_WRAM0    = 4'd4,
		REG_WRAM1    = 4'd5,
		REG_ECHO     = 4'd6,
		REG_OAM      = 4'd7,
		REG_UNUSABLE = 4'd8,
		REG_IO       = 4'd9,
		REG_IO_UNK   = 4'd10,
		REG_HRAM     = 4'd11,
		REG_IE       = 4'd12
	} region_t;

	// Which storage an access reaches in the back end.
	typedef enum logic [2:0] {
		TGT_NONE = 3'd0,
		TGT_ROM  = 3'd1,
		TGT_WRAM = 3'd2,
		TGT_IO   = 3'd3,
		TGT_HRAM = 3'd4,
		TGT_IE   = 3'd5
	} target_t;

	typedef enum logic [IoSelW-1:0] {
		IO_SB   = 5'd0,
		IO_SC   = 5'd1,
		IO_DIV  = 5'd2,
		IO_TIMA = 5'd3,
		IO_TMA  = 5'd4,
		IO_TAC  = 5'd5,
		IO_IF   = 5'd6,
		IO_LCDC = 5'd7,
		IO_SCY  = 5'd8,
		IO_SCX  = 5'd9,
		IO_LY   = 5'd10,
		IO_LYC  = 5'd11,
		IO_BGP  = 5'd12,
		IO_OBP0 = 5'd13,
		IO_OBP1 = 5'd14,
		IO_WY   = 5'd15,
		IO_WX   = 5'd16
	} io_reg_t;

	typedef struct packed {
		logic    hit;
		io_reg_t sel;
	} io_hit_t;

	typedef struct packed {
		logic                is_write;
		region_t             region;
		target_t             target;
		io_reg_t             io_sel;
		logic                serviced;
		logic [WramAw-1:0]   index;
		logic [7:0]          wdata;
		logic [7:0]          rom;
	} cmd_t;

	// Low byte of an FFxx address to I/O register.
	function automatic io_hit_t io_lookup(input logic [7:0] lo);
		io_hit_t r;
		r.hit = 1'b1;
		r.sel = IO_SB;
		case (lo)
			8'h01:   r.sel = IO_SB;
			8'h02:   r.sel = IO_SC;
			8'h04:   r.sel = IO_DIV;
			8'h05:   r.sel = IO_TIMA;
			8'h06:   r.sel = IO_TMA;
			8'h07:   r.sel = IO_TAC;
			8'h0f:   r.sel = IO_IF;
			8'h40:   r.sel = IO_LCDC;
			8'h42:   r.sel = IO_SCY;
			8'h43:   r.sel = IO_SCX;
			8'h44:   r.sel = IO_LY;
			8'h45:   r.sel = IO_LYC;
			8'h47:   r.sel = IO_BGP;
			8'h48:   r.sel = IO_OBP0;
			8'h49:   r.sel = IO_OBP1;
			8'h4a:   r.sel = IO_WY;
			8'h4b:   r.sel = IO_WX;
			default: r.hit = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] io_reset_value(input logic [IoSelW-1:0] sel);
		logic [7:0] v;
		case (sel)
			IO_LCDC: v = 8'h91;
			IO_BGP:  v = 8'hfc;
			IO_OBP0: v = 8'hff;
			IO_OBP1: v = 8'hff;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

### design/hmm_req_if.sv
// Bus access channel: valid/ready plus the access fields.
`default_nettype none
interface hmm_req_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [15:0] address;
	logic [7:0]  write_data;
	logic [7:0]  rom_byte;

	modport source (output valid, output mode, output address, output write_data,
		output rom_byte, input ready);
	modport sink (input valid, input mode, input address, input write_data,
		input rom_byte, output ready);
endinterface
`default_nettype wire

### design/hmm_rsp_if.sv
// Access result channel: valid/ready plus the result fields.
`default_nettype none
interface hmm_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic [3:0] region;
	logic       serviced;

	modport source (output valid, output read_data, output region, output serviced,
		input ready);
	modport sink (input valid, input read_data, input region, input serviced,
		output ready);
endinterface
`default_nettype wire

### design/hmm_queue.sv
// Small FIFO of decoded commands between the front and back ends.
`default_nettype none
module hmm_queue #(
	parameter int Depth = 2
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_valid,
	output logic               push_ready,
	input  wire hmm_pkg::cmd_t push_data,
	output logic               pop_valid,
	input  wire logic          pop,
	output hmm_pkg::cmd_t      pop_data
);
	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	hmm_pkg::cmd_t   mem_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (count_q != CntW'(Depth));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

### design/hmm_front.sv
// Front end: accepts bus accesses and decodes the address into a command.
`default_nettype none
module hmm_front (
	hmm_req_if.sink            req,
	input  wire logic          q_ready,
	input  wire logic          clearing,
	output logic               q_valid,
	output hmm_pkg::cmd_t      q_data
);
	hmm_pkg::io_hit_t io;
	hmm_pkg::cmd_t    cmd;

	assign req.ready = q_ready && !clearing;
	assign q_valid   = req.valid && !clearing;
	assign q_data    = cmd;

	always_comb begin
		io           = hmm_pkg::io_lookup(req.address[7:0]);
		cmd.is_write = req.mode;
		cmd.index    = req.address[hmm_pkg::WramAw-1:0];
		cmd.wdata    = req.write_data;
		cmd.rom      = req.rom_byte;
		cmd.io_sel   = io.sel;
		cmd.target   = hmm_pkg::TGT_NONE;
		cmd.serviced = 1'b0;
		case (req.address) inside
			[16'h0000:16'h3fff]: begin
				cmd.region   = hmm_pkg::REG_ROM0;
				cmd.target   = req.mode ? hmm_pkg::TGT_NONE : hmm_pkg::TGT_ROM;
				cmd.serviced = !req.mode;
			end
			[16'h4000:16'h7fff]: cmd.region = hmm_pkg::REG_ROMX;
			[16'h8000:16'h9fff]: cmd.region = hmm_pkg::REG_VRAM;
			[16'ha000:16'hbfff]: cmd.region = hmm_pkg::REG_EXTRAM;
			[16'hc000:16'hcfff]: begin
				cmd.region   = hmm_pkg::REG_WRAM0;
				cmd.target   = hmm_pkg::TGT_WRAM;
				cmd.serviced = 1'b1;
			end
			[16'hd000:16'hdfff]: cmd.region = hmm_pkg::REG_WRAM1;
			[16'he000:16'hfdff]: cmd.region = hmm_pkg::REG_ECHO;
			[16'hfe00:16'hfe9f]: cmd.region = hmm_pkg::REG_OAM;
			[16'hfea0:16'hfeff]: cmd.region = hmm_pkg::REG_UNUSABLE;
			[16'hff00:16'hff7f]: begin
				if (io.hit) begin
					cmd.region   = hmm_pkg::REG_IO;
					cmd.target   = hmm_pkg::TGT_IO;
					// line counter is read-only
					cmd.serviced = !(req.mode && io.sel == hmm_pkg::IO_LY);
				end else begin
					cmd.region = hmm_pkg::REG_IO_UNK;
				end
			end
			[16'hff80:16'hfffe]: begin
				cmd.region   = hmm_pkg::REG_HRAM;
				cmd.target   = hmm_pkg::TGT_HRAM;
				cmd.serviced = 1'b1;
			end
			default: begin
				cmd.region   = hmm_pkg::REG_IE;
				cmd.target   = hmm_pkg::TGT_IE;
				cmd.serviced = 1'b1;
			end
		endcase
	end
endmodule
`default_nettype wire

### design/hmm_back.sv
// Back end: clearing pass, RAMs, I/O registers and the result register.
`default_nettype none
module hmm_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_valid,
	output logic               q_pop,
	input  wire hmm_pkg::cmd_t q_data,
	output logic               clearing,
	hmm_rsp_if.source          rsp
);
	localparam int WramAw = hmm_pkg::WramAw;
	localparam int HramAw = hmm_pkg::HramAw;

	logic [7:0]          wram_q [hmm_pkg::WramDepth];
	logic [7:0]          hram_q [hmm_pkg::HramDepth];
	logic [7:0]          io_q   [hmm_pkg::IoCount];
	logic [7:0]          ie_q;

	logic                clearing_q;
	logic [WramAw-1:0]   clr_idx_q;

	logic                vld_q;
	logic                is_write_q;
	hmm_pkg::region_t    region_q;
	hmm_pkg::target_t    target_q;
	logic                serviced_q;
	logic [7:0]          rom_q;
	logic [7:0]          reg_rd_q;
	logic [7:0]          wram_rd_q;
	logic [7:0]          hram_rd_q;

	logic                pop;
	logic                wr;
	logic [HramAw-1:0]   hidx;
	logic [7:0]          rdata;

	assign pop      = q_valid && !clearing_q && (!vld_q || rsp.ready);
	assign q_pop    = pop;
	assign clearing = clearing_q;
	assign wr       = pop && q_data.is_write;
	assign hidx     = q_data.index[HramAw-1:0];

	// clearing pass: one work RAM entry per cycle (and one high RAM entry while the index is within high RAM)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == {WramAw{1'b1}}) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			wram_q[clr_idx_q] <= '0;
		end else if (wr && q_data.target == hmm_pkg::TGT_WRAM) begin
			wram_q[q_data.index] <= q_data.wdata;
		end
		if (pop && q_data.target == hmm_pkg::TGT_WRAM) begin
			wram_rd_q <= wram_q[q_data.index];
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			if (clr_idx_q < WramAw'(hmm_pkg::HramDepth)) begin
				hram_q[clr_idx_q[HramAw-1:0]] <= '0;
			end
		end else if (wr && q_data.target == hmm_pkg::TGT_HRAM) begin
			hram_q[hidx] <= q_data.wdata;
		end
		if (pop && q_data.target == hmm_pkg::TGT_HRAM) begin
			hram_rd_q <= hram_q[hidx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < hmm_pkg::IoCount; i++) begin
				io_q[i] <= hmm_pkg::io_reset_value(hmm_pkg::IoSelW'(i));
			end
			ie_q <= 8'h00;
		end else if (wr) begin
			if (q_data.target == hmm_pkg::TGT_IO) begin
				if (q_data.io_sel == hmm_pkg::IO_DIV) begin
					io_q[q_data.io_sel] <= 8'h00;
				end else if (q_data.io_sel != hmm_pkg::IO_LY) begin
					io_q[q_data.io_sel] <= q_data.wdata;
				end
			end else if (q_data.target == hmm_pkg::TGT_IE) begin
				ie_q <= q_data.wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			is_write_q <= q_data.is_write;
			region_q   <= q_data.region;
			target_q   <= q_data.target;
			serviced_q <= q_data.serviced;
			rom_q      <= q_data.rom;
			reg_rd_q   <= (q_data.target == hmm_pkg::TGT_IE) ? ie_q : io_q[q_data.io_sel];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (pop) begin
			vld_q <= 1'b1;
		end else if (rsp.ready) begin
			vld_q <= 1'b0;
		end
	end

	always_comb begin
		case (target_q)
			hmm_pkg::TGT_ROM:  rdata = rom_q;
			hmm_pkg::TGT_WRAM: rdata = wram_rd_q;
			hmm_pkg::TGT_HRAM: rdata = hram_rd_q;
			hmm_pkg::TGT_IO:   rdata = reg_rd_q;
			hmm_pkg::TGT_IE:   rdata = reg_rd_q;
			default:           rdata = 8'h00;
		endcase
	end

	assign rsp.valid     = vld_q;
	assign rsp.read_data = is_write_q ? 8'h00 : rdata;
	assign rsp.region    = region_q;
	assign rsp.serviced  = serviced_q;

`ifndef NO_ASSERTIONS
	a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !vld_q)
		else $error("result present during clearing pass");

	a_write_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && is_write_q |-> rsp.read_data == 8'h00)
		else $error("write item returned nonzero read data");

	a_serviced_region: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q && serviced_q |-> region_q == hmm_pkg::REG_ROM0 ||
			region_q == hmm_pkg::REG_WRAM0 || region_q == hmm_pkg::REG_IO ||
			region_q == hmm_pkg::REG_HRAM || region_q == hmm_pkg::REG_IE)
		else $error("serviced item in an unmodelled region");

	a_clear_full_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clearing_q) |-> $past(clr_idx_q) == {WramAw{1'b1}})
		else $error("clearing pass ended early");
`endif
endmodule
`default_nettype wire

### design/handheld_memory_map_bus_slave_top.sv
// Items pass through the queue and then the result register; one item per cycle while
// rsp.ready is high. The queue and the result register decouple both sides.
// Rate is set by the single-port work RAM and high RAM, one access each per cycle.
// Reset (arst_n, async low) clears control and I/O registers, then a clearing pass
// over all 4096 work RAM entries zeroes work RAM and high RAM; no item is accepted during it.
`default_nettype none
module handheld_memory_map_bus_slave_top #(
	parameter int QueueDepth = 2
) (
	input  wire logic clk,
	input  wire logic arst_n,
	hmm_req_if.sink   req,
	hmm_rsp_if.source rsp
);
	logic          fq_valid;
	logic          fq_ready;
	hmm_pkg::cmd_t fq_data;
	logic          bq_valid;
	logic          bq_pop;
	hmm_pkg::cmd_t bq_data;
	logic          clearing;

	hmm_front u_front (
		.req      (req),
		.q_ready  (fq_ready),
		.clearing (clearing),
		.q_valid  (fq_valid),
		.q_data   (fq_data)
	);

	hmm_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (fq_data),
		.pop_valid  (bq_valid),
		.pop        (bq_pop),
		.pop_data   (bq_data)
	);

	hmm_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (bq_valid),
		.q_pop    (bq_pop),
		.q_data   (bq_data),
		.clearing (clearing),
		.rsp      (rsp)
	);
endmodule
`default_nettype wire
